### src/rbvq_pkg.sv
package rbvq_pkg;

    // input beat: start and destination vectors
    typedef struct packed {
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] start_z;
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic signed [15:0] dest_z;
    } in_beat_t;

    // result beat: Q1.14 quaternion and flags
    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic               opposite_case;
        logic               degenerate;
    } out_beat_t;

    localparam int LEN_W   = 30;   // root bits of a vector length in Q14
    localparam int UQ_W    = 29;   // quotient bits of a unit component
    localparam int ROOT_W  = 30;   // root bits of the second square root
    localparam int WROOT_W = 15;   // root bits of the scalar part
    localparam int QQ_W    = 15;   // quotient bits of a vector part

    localparam logic signed [61:0] Q56One      = 62'sd72057594037927936;
    localparam logic signed [61:0] DotOppLimit = -62'sd71985536443890008;
    localparam logic [60:0]        AxisMin2    = 61'd720575940379279;
    localparam logic [15:0]        QMax        = 16'd16384;

    // one root bit of a restoring square root
    typedef struct packed {
        logic [61:0] rem;
        logic [29:0] root;
    } sqrt_st_t;

    // one quotient bit of a unit component division
    typedef struct packed {
        logic [59:0] rem;
        logic [28:0] q;
    } udiv_st_t;

    // one quotient bit of a vector part division
    typedef struct packed {
        logic [63:0] rem;
        logic [14:0] q;
    } qdiv_st_t;

    function automatic sqrt_st_t sqrt_step(sqrt_st_t cur, int b);
        logic [61:0] trial;
        sqrt_st_t    nx;
        trial = (62'(cur.root) << (b + 1)) + (62'(1) << (2 * b));
        nx = cur;
        if (cur.rem >= trial) begin
            nx.rem  = cur.rem - trial;
            nx.root = cur.root | (30'(1) << b);
        end
        return nx;
    endfunction

    function automatic udiv_st_t udiv_step(udiv_st_t cur, logic [29:0] den, int b);
        logic [59:0] dd;
        udiv_st_t    nx;
        dd = 60'(den) << b;
        nx = cur;
        if (cur.rem >= dd) begin
            nx.rem = cur.rem - dd;
            nx.q   = cur.q | (29'(1) << b);
        end
        return nx;
    endfunction

    function automatic qdiv_st_t qdiv_step(qdiv_st_t cur, logic [44:0] den, int b);
        logic [63:0] dd;
        qdiv_st_t    nx;
        dd = 64'(den) << b;
        nx = cur;
        if (cur.rem >= dd) begin
            nx.rem = cur.rem - dd;
            nx.q   = cur.q | (15'(1) << b);
        end
        return nx;
    endfunction

endpackage

### src/rotation_between_vectors_quat_unit.sv
// rotation between two vectors as a unit quaternion
// s_ channel: one beat holds a start and a destination 3-vector, 16-bit signed.
// m_ channel: one beat holds w, x, y, z in signed Q1.14 plus the opposite_case
//   flag (half turn about a fallback axis) and the degenerate flag (zero vector).
// throughput: one beat per cycle; every stage is a fixed register, so a beat
//   enters each cycle that the output side is not stalled.
// stages: the pipeline has 114 register stages, most of them in the two 30-step
//   square roots and the 29-step and 15-step restoring dividers, one root or
//   quotient bit per stage; a beat stays in its stage while the pipeline is held.
// stall: while m_valid is high and m_ready low the whole pipeline holds; the
//   input skid register still takes one beat, after which s_ready drops.
// reset: aresetn, synchronous, active low, clears all valid bits; the pipeline
//   is empty and s_ready is high in the first cycle after reset.
module rotation_between_vectors_quat_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rbvq_pkg::in_beat_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rbvq_pkg::out_beat_t  m_data
);

    typedef struct packed {
        rbvq_pkg::in_beat_t vec;
        logic               deg;
        rbvq_pkg::sqrt_st_t ls;
        rbvq_pkg::sqrt_st_t ld;
    } nrm_t;

    typedef struct packed {
        logic                          deg;
        logic [5:0]                    neg;
        logic [29:0]                   len_s;
        logic [29:0]                   len_d;
        rbvq_pkg::udiv_st_t [5:0]      lane;
    } udv_t;

    typedef struct packed {
        logic                          deg;
        logic                          opp;
        logic [2:0][61:0]              num;
        rbvq_pkg::sqrt_st_t            m;
        rbvq_pkg::sqrt_st_t            w;
    } rt_t;

    typedef struct packed {
        logic                          deg;
        logic                          opp;
        logic [14:0]                   w;
        logic [2:0]                    neg;
        logic [2:0]                    ovf;
        logic                          zero;
        logic [44:0]                   den;
        rbvq_pkg::qdiv_st_t [2:0]      lane;
    } qdv_t;

    logic adv;

    logic               skid_valid_reg;
    rbvq_pkg::in_beat_t skid_data_reg;
    logic               front_v;
    rbvq_pkg::in_beat_t front_d;

    logic               p0_v_reg;
    rbvq_pkg::in_beat_t p0_reg;
    logic               p1_v_reg;
    rbvq_pkg::in_beat_t p1_vec_reg;
    logic [5:0][30:0]   p1_sq_reg;

    logic [rbvq_pkg::LEN_W:0] nrm_v_reg;
    nrm_t                     nrm_reg [0:rbvq_pkg::LEN_W];
    logic [rbvq_pkg::UQ_W:0]  udv_v_reg;
    udv_t                     udv_reg [0:rbvq_pkg::UQ_W];

    logic                     u_v_reg;
    logic                     u_deg_reg;
    logic signed [29:0]       us_reg [3];
    logic signed [29:0]       ud_reg [3];

    logic                     m_v_reg;
    logic                     m_deg_reg;
    logic signed [29:0]       mu_reg [3];
    logic signed [59:0]       pdot_reg [3];
    logic signed [59:0]       pcr_reg [6];
    logic signed [59:0]       psq_reg [3];

    logic                     s_v_reg;
    logic                     s_deg_reg;
    logic signed [29:0]       su_reg [3];
    logic signed [61:0]       dot_reg;
    logic signed [61:0]       k_reg [3];
    logic [60:0]              l2a_reg;
    logic [60:0]              l2b_reg;

    logic [rbvq_pkg::ROOT_W:0] rt_v_reg;
    rt_t                       rt_reg [0:rbvq_pkg::ROOT_W];
    logic [rbvq_pkg::QQ_W:0]   qdv_v_reg;
    qdv_t                      qdv_reg [0:rbvq_pkg::QQ_W];

    logic                 m_valid_reg;
    rbvq_pkg::out_beat_t  m_data_reg;
    rbvq_pkg::out_beat_t  m_data_next;

    // global advance: output register free or being drained
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = !skid_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign front_v = skid_valid_reg || s_valid;
    assign front_d = skid_valid_reg ? skid_data_reg : s_data;

    // input skid register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (adv) begin
            skid_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!adv && s_valid && s_ready) begin
            skid_data_reg <= s_data;
        end
    end

    // input register and component squares
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_v_reg <= 1'b0;
            p1_v_reg <= 1'b0;
            nrm_v_reg[0] <= 1'b0;
        end else if (adv) begin
            p0_v_reg <= front_v;
            p1_v_reg <= p0_v_reg;
            nrm_v_reg[0] <= p1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p0_reg       <= front_d;
            p1_vec_reg   <= p0_reg;
            p1_sq_reg[0] <= 31'(p0_reg.start_x * p0_reg.start_x);
            p1_sq_reg[1] <= 31'(p0_reg.start_y * p0_reg.start_y);
            p1_sq_reg[2] <= 31'(p0_reg.start_z * p0_reg.start_z);
            p1_sq_reg[3] <= 31'(p0_reg.dest_x * p0_reg.dest_x);
            p1_sq_reg[4] <= 31'(p0_reg.dest_y * p0_reg.dest_y);
            p1_sq_reg[5] <= 31'(p0_reg.dest_z * p0_reg.dest_z);
        end
    end

    // squared lengths, shifted into Q28 radicands
    always_ff @(posedge aclk) begin
        logic [31:0] n2s;
        logic [31:0] n2d;
        n2s = 32'(p1_sq_reg[0]) + 32'(p1_sq_reg[1]) + 32'(p1_sq_reg[2]);
        n2d = 32'(p1_sq_reg[3]) + 32'(p1_sq_reg[4]) + 32'(p1_sq_reg[5]);
        if (adv) begin
            nrm_reg[0].vec     <= p1_vec_reg;
            nrm_reg[0].deg     <= (n2s == 32'd0) || (n2d == 32'd0);
            nrm_reg[0].ls.rem  <= 62'(n2s) << 28;
            nrm_reg[0].ls.root <= '0;
            nrm_reg[0].ld.rem  <= 62'(n2d) << 28;
            nrm_reg[0].ld.root <= '0;
        end
    end

    // vector lengths, one root bit per stage
    for (genvar j = 1; j <= rbvq_pkg::LEN_W; j++) begin : g_len
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                nrm_v_reg[j] <= 1'b0;
            end else if (adv) begin
                nrm_v_reg[j] <= nrm_v_reg[j-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                nrm_reg[j].vec <= nrm_reg[j-1].vec;
                nrm_reg[j].deg <= nrm_reg[j-1].deg;
                nrm_reg[j].ls  <= rbvq_pkg::sqrt_step(nrm_reg[j-1].ls, rbvq_pkg::LEN_W - j);
                nrm_reg[j].ld  <= rbvq_pkg::sqrt_step(nrm_reg[j-1].ld, rbvq_pkg::LEN_W - j);
            end
        end
    end

    // rounded numerators for the unit components
    always_ff @(posedge aclk) begin
        logic signed [15:0] comp [6];
        logic [16:0]        cmag;
        logic [29:0]        den;
        comp[0] = nrm_reg[rbvq_pkg::LEN_W].vec.start_x;
        comp[1] = nrm_reg[rbvq_pkg::LEN_W].vec.start_y;
        comp[2] = nrm_reg[rbvq_pkg::LEN_W].vec.start_z;
        comp[3] = nrm_reg[rbvq_pkg::LEN_W].vec.dest_x;
        comp[4] = nrm_reg[rbvq_pkg::LEN_W].vec.dest_y;
        comp[5] = nrm_reg[rbvq_pkg::LEN_W].vec.dest_z;
        if (!aresetn) begin
            udv_v_reg[0] <= 1'b0;
        end else if (adv) begin
            udv_v_reg[0] <= nrm_v_reg[rbvq_pkg::LEN_W];
        end
        if (adv) begin
            udv_reg[0].deg   <= nrm_reg[rbvq_pkg::LEN_W].deg;
            udv_reg[0].len_s <= nrm_reg[rbvq_pkg::LEN_W].ls.root;
            udv_reg[0].len_d <= nrm_reg[rbvq_pkg::LEN_W].ld.root;
            for (int i = 0; i < 6; i++) begin
                den  = (i < 3) ? nrm_reg[rbvq_pkg::LEN_W].ls.root
                               : nrm_reg[rbvq_pkg::LEN_W].ld.root;
                cmag = comp[i][15] ? -17'(comp[i]) : 17'(comp[i]);
                udv_reg[0].neg[i]      <= comp[i][15];
                udv_reg[0].lane[i].rem <= (60'(cmag) << 42) + 60'(den >> 1);
                udv_reg[0].lane[i].q   <= '0;
            end
        end
    end

    // unit component division, one quotient bit per stage
    for (genvar j = 1; j <= rbvq_pkg::UQ_W; j++) begin : g_udiv
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                udv_v_reg[j] <= 1'b0;
            end else if (adv) begin
                udv_v_reg[j] <= udv_v_reg[j-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                udv_reg[j].deg   <= udv_reg[j-1].deg;
                udv_reg[j].neg   <= udv_reg[j-1].neg;
                udv_reg[j].len_s <= udv_reg[j-1].len_s;
                udv_reg[j].len_d <= udv_reg[j-1].len_d;
                for (int i = 0; i < 6; i++) begin
                    udv_reg[j].lane[i] <= rbvq_pkg::udiv_step(udv_reg[j-1].lane[i],
                        (i < 3) ? udv_reg[j-1].len_s : udv_reg[j-1].len_d,
                        rbvq_pkg::UQ_W - j);
                end
            end
        end
    end

    // signed unit vectors, products, then sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_v_reg <= 1'b0;
            m_v_reg <= 1'b0;
            s_v_reg <= 1'b0;
        end else if (adv) begin
            u_v_reg <= udv_v_reg[rbvq_pkg::UQ_W];
            m_v_reg <= u_v_reg;
            s_v_reg <= m_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic [29:0] qv;
        if (adv) begin
            u_deg_reg <= udv_reg[rbvq_pkg::UQ_W].deg;
            for (int i = 0; i < 3; i++) begin
                qv = 30'(udv_reg[rbvq_pkg::UQ_W].lane[i].q);
                us_reg[i] <= udv_reg[rbvq_pkg::UQ_W].neg[i] ? -qv : qv;
                qv = 30'(udv_reg[rbvq_pkg::UQ_W].lane[i+3].q);
                ud_reg[i] <= udv_reg[rbvq_pkg::UQ_W].neg[i+3] ? -qv : qv;
            end
            m_deg_reg <= u_deg_reg;
            for (int i = 0; i < 3; i++) begin
                mu_reg[i]   <= us_reg[i];
                pdot_reg[i] <= 60'(us_reg[i]) * 60'(ud_reg[i]);
                psq_reg[i]  <= 60'(us_reg[i]) * 60'(us_reg[i]);
            end
            pcr_reg[0] <= 60'(us_reg[1]) * 60'(ud_reg[2]);
            pcr_reg[1] <= 60'(us_reg[2]) * 60'(ud_reg[1]);
            pcr_reg[2] <= 60'(us_reg[2]) * 60'(ud_reg[0]);
            pcr_reg[3] <= 60'(us_reg[0]) * 60'(ud_reg[2]);
            pcr_reg[4] <= 60'(us_reg[0]) * 60'(ud_reg[1]);
            pcr_reg[5] <= 60'(us_reg[1]) * 60'(ud_reg[0]);
            s_deg_reg <= m_deg_reg;
            su_reg    <= mu_reg;
            dot_reg   <= 62'(pdot_reg[0]) + 62'(pdot_reg[1]) + 62'(pdot_reg[2]);
            k_reg[0]  <= 62'(pcr_reg[0]) - 62'(pcr_reg[1]);
            k_reg[1]  <= 62'(pcr_reg[2]) - 62'(pcr_reg[3]);
            k_reg[2]  <= 62'(pcr_reg[4]) - 62'(pcr_reg[5]);
            l2a_reg   <= 61'(psq_reg[1]) + 61'(psq_reg[0]);
            l2b_reg   <= 61'(psq_reg[2]) + 61'(psq_reg[1]);
        end
    end

    // branch choice, radicands and numerators
    always_ff @(posedge aclk) begin
        logic               opp;
        logic               alt;
        logic signed [61:0] t;
        logic [60:0]        l2;
        if (!aresetn) begin
            rt_v_reg[0] <= 1'b0;
        end else if (adv) begin
            rt_v_reg[0] <= s_v_reg;
        end
        opp = !s_deg_reg && (dot_reg < rbvq_pkg::DotOppLimit);
        t   = dot_reg + rbvq_pkg::Q56One;
        if (t < 0) begin
            t = '0;
        end
        alt = l2a_reg < rbvq_pkg::AxisMin2;
        l2  = alt ? l2b_reg : l2a_reg;
        if (adv) begin
            rt_reg[0].deg    <= s_deg_reg;
            rt_reg[0].opp    <= opp;
            rt_reg[0].m.root <= '0;
            rt_reg[0].w.root <= '0;
            if (opp) begin
                rt_reg[0].m.rem <= 62'(l2);
                rt_reg[0].w.rem <= '0;
                if (alt) begin
                    rt_reg[0].num[0] <= '0;
                    rt_reg[0].num[1] <= (-62'(su_reg[2])) <<< 14;
                    rt_reg[0].num[2] <= 62'(su_reg[1]) <<< 14;
                end else begin
                    rt_reg[0].num[0] <= (-62'(su_reg[1])) <<< 14;
                    rt_reg[0].num[1] <= 62'(su_reg[0]) <<< 14;
                    rt_reg[0].num[2] <= '0;
                end
            end else begin
                rt_reg[0].m.rem  <= 62'($unsigned(t)) << 1;
                rt_reg[0].w.rem  <= 62'($unsigned(t)) >> 29;
                rt_reg[0].num[0] <= k_reg[0];
                rt_reg[0].num[1] <= k_reg[1];
                rt_reg[0].num[2] <= k_reg[2];
            end
        end
    end

    // divisor root and scalar root; the scalar root runs in the later stages
    for (genvar j = 1; j <= rbvq_pkg::ROOT_W; j++) begin : g_root
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rt_v_reg[j] <= 1'b0;
            end else if (adv) begin
                rt_v_reg[j] <= rt_v_reg[j-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                rt_reg[j].deg <= rt_reg[j-1].deg;
                rt_reg[j].opp <= rt_reg[j-1].opp;
                rt_reg[j].num <= rt_reg[j-1].num;
                rt_reg[j].m   <= rbvq_pkg::sqrt_step(rt_reg[j-1].m, rbvq_pkg::ROOT_W - j);
                if (rbvq_pkg::ROOT_W - j < rbvq_pkg::WROOT_W) begin
                    rt_reg[j].w <= rbvq_pkg::sqrt_step(rt_reg[j-1].w, rbvq_pkg::ROOT_W - j);
                end else begin
                    rt_reg[j].w <= rt_reg[j-1].w;
                end
            end
        end
    end

    // scalar rounding, divisor, rounded numerators and overflow check
    always_ff @(posedge aclk) begin
        logic [44:0]        den;
        logic [63:0]        numr;
        logic signed [61:0] nv;
        logic [61:0]        nmag;
        logic [29:0]        wr;
        if (!aresetn) begin
            qdv_v_reg[0] <= 1'b0;
        end else if (adv) begin
            qdv_v_reg[0] <= rt_v_reg[rbvq_pkg::ROOT_W];
        end
        den = rt_reg[rbvq_pkg::ROOT_W].opp ? 45'(rt_reg[rbvq_pkg::ROOT_W].m.root)
                                           : 45'(rt_reg[rbvq_pkg::ROOT_W].m.root) << 14;
        wr  = rt_reg[rbvq_pkg::ROOT_W].w.root;
        if (rt_reg[rbvq_pkg::ROOT_W].w.rem > 62'(wr)) begin
            wr = wr + 30'd1;
        end
        if (adv) begin
            qdv_reg[0].deg  <= rt_reg[rbvq_pkg::ROOT_W].deg;
            qdv_reg[0].opp  <= rt_reg[rbvq_pkg::ROOT_W].opp;
            qdv_reg[0].w    <= (wr > 30'(rbvq_pkg::QMax)) ? 15'(rbvq_pkg::QMax) : 15'(wr);
            qdv_reg[0].den  <= den;
            qdv_reg[0].zero <= den == '0;
            for (int i = 0; i < 3; i++) begin
                nv   = rt_reg[rbvq_pkg::ROOT_W].num[i];
                nmag = nv[61] ? 62'(-nv) : 62'(nv);
                numr = 64'(nmag) + 64'(den >> 1);
                qdv_reg[0].neg[i]      <= nv[61];
                qdv_reg[0].ovf[i]      <= numr >= (64'(den) << rbvq_pkg::QQ_W);
                qdv_reg[0].lane[i].rem <= numr;
                qdv_reg[0].lane[i].q   <= '0;
            end
        end
    end

    // vector part division, one quotient bit per stage
    for (genvar j = 1; j <= rbvq_pkg::QQ_W; j++) begin : g_qdiv
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                qdv_v_reg[j] <= 1'b0;
            end else if (adv) begin
                qdv_v_reg[j] <= qdv_v_reg[j-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                qdv_reg[j].deg  <= qdv_reg[j-1].deg;
                qdv_reg[j].opp  <= qdv_reg[j-1].opp;
                qdv_reg[j].w    <= qdv_reg[j-1].w;
                qdv_reg[j].neg  <= qdv_reg[j-1].neg;
                qdv_reg[j].ovf  <= qdv_reg[j-1].ovf;
                qdv_reg[j].zero <= qdv_reg[j-1].zero;
                qdv_reg[j].den  <= qdv_reg[j-1].den;
                for (int i = 0; i < 3; i++) begin
                    qdv_reg[j].lane[i] <= rbvq_pkg::qdiv_step(qdv_reg[j-1].lane[i],
                        qdv_reg[j-1].den, rbvq_pkg::QQ_W - j);
                end
            end
        end
    end

    // clamp, sign and flags of the result beat
    always_comb begin
        logic [15:0] mag [3];
        qdv_t        last;
        last = qdv_reg[rbvq_pkg::QQ_W];
        for (int i = 0; i < 3; i++) begin
            if (last.zero || last.deg) begin
                mag[i] = '0;
            end else if (last.ovf[i] || (16'(last.lane[i].q) > rbvq_pkg::QMax)) begin
                mag[i] = rbvq_pkg::QMax;
            end else begin
                mag[i] = 16'(last.lane[i].q);
            end
        end
        m_data_next.quat_w        = (last.deg || last.opp) ? '0 : 16'(last.w);
        m_data_next.quat_x        = last.neg[0] ? -mag[0] : mag[0];
        m_data_next.quat_y        = last.neg[1] ? -mag[1] : mag[1];
        m_data_next.quat_z        = last.neg[2] ? -mag[2] : mag[2];
        m_data_next.opposite_case = last.opp;
        m_data_next.degenerate    = last.deg;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= qdv_v_reg[rbvq_pkg::QQ_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

`ifndef SYNTHESIS
    // zero-length input gives an all-zero quaternion and no half-turn flag
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |->
            m_data.quat_w == 16'sd0 && m_data.quat_x == 16'sd0 &&
            m_data.quat_y == 16'sd0 && m_data.quat_z == 16'sd0 &&
            !m_data.opposite_case)
        else $error("degenerate beat with nonzero result");

    // half turn has no scalar part
    a_opp_w: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.opposite_case |-> m_data.quat_w == 16'sd0)
        else $error("half turn with nonzero w");

    // components stay in the Q1.14 range, w never negative
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            m_data.quat_w >= 16'sd0 && m_data.quat_w <= 16'sd16384 &&
            m_data.quat_x >= -16'sd16384 && m_data.quat_x <= 16'sd16384 &&
            m_data.quat_y >= -16'sd16384 && m_data.quat_y <= 16'sd16384 &&
            m_data.quat_z >= -16'sd16384 && m_data.quat_z <= 16'sd16384)
        else $error("quaternion component out of range");
`endif

endmodule
